// ----- sv/wzh_pkg.sv -----
// ----------------------------------------------------------------------------
// wzh_pkg
// shared types and constants of the window stacking-order hit test
// ----------------------------------------------------------------------------
`default_nettype none
package wzh_pkg;

   localparam int CoordW = 12;
   localparam int IdentW = 16;
   localparam int MaxResults = 16;
   localparam int MaxUpdates = MaxResults - 1;

   localparam logic [1:0] KIND_ALLOC    = 2'd0;
   localparam logic [1:0] KIND_RELEASE  = 2'd1;
   localparam logic [1:0] KIND_ACTIVATE = 2'd2;
   localparam logic [1:0] KIND_HIT      = 2'd3;

   typedef struct packed {
      logic [CoordW-1:0] left;
      logic [CoordW-1:0] top;
      logic [CoordW-1:0] right;
      logic [CoordW-1:0] bottom;
   } rect_type;

   typedef struct packed {
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
   } point_type;

   typedef enum logic [1:0] {
      STK_NONE,
      STK_PUSH,
      STK_REMOVE,
      STK_TO_TOP
   } stk_op_type;

endpackage
`default_nettype wire

// ----- sv/wzh_rect_cmp.sv -----
// ----------------------------------------------------------------------------
// wzh_rect_cmp
// shared compare unit: point inside a half-open rectangle
// ----------------------------------------------------------------------------
`default_nettype none
module wzh_rect_cmp (
   input  wire wzh_pkg::rect_type  rect,
   input  wire wzh_pkg::point_type pt,
   output logic                    hit
);
   import wzh_pkg::*;

   assign hit = (rect.left <= pt.x) && (rect.right > pt.x) &&
                (rect.top <= pt.y) && (rect.bottom > pt.y);
endmodule
`default_nettype wire

// ----- sv/wzh_stack.sv -----
// ----------------------------------------------------------------------------
// wzh_stack
// stacking order store, bottom to top, with push, remove and move to top
// ----------------------------------------------------------------------------
`default_nettype none
module wzh_stack #(
   parameter int MAX_WINDOWS = 16,
   localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1,
   localparam int CW = $clog2(MAX_WINDOWS + 1)
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire wzh_pkg::stk_op_type op,
   input  wire [SW-1:0]             pos,
   input  wire [SW-1:0]             slot,
   output logic [SW-1:0]            rd_slot,
   output logic [CW-1:0]            count
);
   import wzh_pkg::*;

   logic [SW-1:0] order_ff [MAX_WINDOWS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_m1;

   assign count    = count_ff;
   assign count_m1 = count_ff - 1'b1;
   assign rd_slot  = order_ff[pos];

   always_ff @(posedge clock) begin
      unique case (op)
         STK_PUSH: begin
            order_ff[count_ff[SW-1:0]] <= slot;
         end
         STK_REMOVE, STK_TO_TOP: begin
            for (int i = 0; i < MAX_WINDOWS - 1; i++) begin
               if (i >= int'(pos) && i + 1 < int'(count_ff)) begin
                  order_ff[i] <= order_ff[i+1];
               end
            end
            if (op == STK_TO_TOP) begin
               order_ff[count_m1[SW-1:0]] <= slot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (op == STK_PUSH) begin
         count_ff <= count_ff + 1'b1;
      end else if (op == STK_REMOVE) begin
         count_ff <= count_m1;
      end
   end
endmodule
`default_nettype wire

// ----- sv/window_zorder_hit_test.sv -----
// ----------------------------------------------------------------------------
// window_zorder_hit_test
// window table with a bottom-to-top stacking order: allocate, release,
// activate and hit test, walked one slot or stack entry per cycle
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  kind, window id, rectangle, owner, point
//  rsp_      out        rsp_valid/rsp_stall  result kind, status, ident, owner pid, last
//
//  one request at a time; a walk visits one slot or one stack entry per cycle
//  allocate scans for a free slot and activate finds the window, each then sends
//  an update on success and then the reply; release finds it, sends one update
//  per remaining window on success, then the reply; hit test walks the stack top down
//  and replies; synchronous active-high reset empties the table, next id becomes one
//  rsp_stall holds the walk only while a result waits; req_stall high when busy
`default_nettype none
module window_zorder_hit_test #(
   parameter int MAX_WINDOWS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_kind,
   input  wire  [15:0] req_window_id,
   input  wire  [11:0] req_left_x,
   input  wire  [11:0] req_top_y,
   input  wire  [11:0] req_right_x,
   input  wire  [11:0] req_bottom_y,
   input  wire  [15:0] req_owner,
   input  wire  [11:0] req_point_x,
   input  wire  [11:0] req_point_y,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_result_kind,
   output logic        rsp_status,
   output logic [15:0] rsp_window_ident,
   output logic [15:0] rsp_owner_pid,
   output logic        rsp_last
);
   import wzh_pkg::*;

   localparam int SW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CW = $clog2(MAX_WINDOWS + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_WINDOWS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FREE,
      ST_FIND,
      ST_PAINT,
      ST_HIT,
      ST_UPD,
      ST_REPLY
   } state_type;

   state_type state_ff;

   // latched request
   logic [1:0]        kind_ff;
   logic [IdentW-1:0] wid_ff;
   logic [IdentW-1:0] owner_ff;
   rect_type          new_rect_ff;
   point_type         pt_ff;

   // walk index and pending reply
   logic [CW-1:0]     idx_ff;
   logic              rep_st_ff;
   logic [IdentW-1:0] rep_ident_ff;
   logic [IdentW-1:0] rep_pid_ff;
   logic [IdentW-1:0] next_ident_ff;

   // slot table
   logic              used_ff  [MAX_WINDOWS];
   logic [IdentW-1:0] ident_ff [MAX_WINDOWS];
   logic [IdentW-1:0] sowner_ff[MAX_WINDOWS];
   rect_type          rect_ff  [MAX_WINDOWS];

   // output register
   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic              rsp_st_ff;
   logic [IdentW-1:0] rsp_ident_ff;
   logic [IdentW-1:0] rsp_pid_ff;
   logic              rsp_last_ff;

   logic          out_free;
   logic          rsp_load;
   logic [CW-1:0] idx_m1;
   logic [SW-1:0] rd_pos;
   logic [SW-1:0] stk_slot;
   logic [SW-1:0] rd_slot;
   logic [CW-1:0] count;
   stk_op_type    stk_op;
   logic          table_full;
   logic          free_found;
   logic          id_match;
   logic          find_end;
   logic          paint_more;
   logic          pt_hit;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   // a new result goes into the output register this cycle
   assign rsp_load = out_free && (((state_ff == ST_PAINT) && paint_more) ||
                                  (state_ff == ST_UPD) || (state_ff == ST_REPLY));
   assign idx_m1   = idx_ff - 1'b1;
   assign rd_pos   = (state_ff == ST_HIT) ? idx_m1[SW-1:0] : idx_ff[SW-1:0];
   // free scan walks slots directly, everything else walks the stack
   assign rd_slot  = (state_ff == ST_FREE) ? idx_ff[SW-1:0] : stk_slot;

   assign table_full = (idx_ff == MaxCount) || (count >= MaxCount);
   assign free_found = (state_ff == ST_FREE) && !table_full && !used_ff[rd_slot];
   assign find_end   = idx_ff >= count;
   assign id_match   = (state_ff == ST_FIND) && !find_end &&
                       used_ff[rd_slot] && (ident_ff[rd_slot] == wid_ff);
   assign paint_more = (idx_ff < count) && (int'(idx_ff) < MaxUpdates);

   always_comb begin
      stk_op = STK_NONE;
      if (free_found) begin
         stk_op = STK_PUSH;
      end else if (id_match) begin
         stk_op = (kind_ff == KIND_RELEASE) ? STK_REMOVE : STK_TO_TOP;
      end
   end

   wzh_stack #(.MAX_WINDOWS(MAX_WINDOWS)) u_stack (
      .clock  (clock),
      .reset  (reset),
      .op     (stk_op),
      .pos    (rd_pos),
      .slot   (rd_slot),
      .rd_slot(stk_slot),
      .count  (count)
   );

   wzh_rect_cmp u_cmp (
      .rect(rect_ff[rd_slot]),
      .pt  (pt_ff),
      .hit (pt_hit)
   );

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_window_ident = rsp_ident_ff;
   assign rsp_owner_pid    = rsp_pid_ff;
   assign rsp_last         = rsp_last_ff;

   // rectangles carry no reset, read only for live windows
   always_ff @(posedge clock) begin
      if (free_found) begin
         rect_ff[rd_slot] <= new_rect_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         next_ident_ff <= IdentW'(1);
         for (int i = 0; i < MAX_WINDOWS; i++) begin
            used_ff[i]   <= 1'b0;
            ident_ff[i]  <= '0;
            sowner_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff            <= req_kind;
                  wid_ff             <= req_window_id;
                  owner_ff           <= req_owner;
                  new_rect_ff.left   <= req_left_x;
                  new_rect_ff.top    <= req_top_y;
                  new_rect_ff.right  <= req_right_x;
                  new_rect_ff.bottom <= req_bottom_y;
                  pt_ff.x            <= req_point_x;
                  pt_ff.y            <= req_point_y;
                  rep_st_ff          <= 1'b1;
                  rep_ident_ff       <= '0;
                  rep_pid_ff         <= '0;
                  unique case (req_kind)
                     KIND_ALLOC: begin
                        idx_ff   <= '0;
                        state_ff <= ST_FREE;
                     end
                     KIND_RELEASE, KIND_ACTIVATE: begin
                        idx_ff   <= '0;
                        state_ff <= ST_FIND;
                     end
                     default: begin
                        idx_ff   <= count;
                        state_ff <= ST_HIT;
                     end
                  endcase
               end
            end
            ST_FREE: begin
               if (table_full) begin
                  state_ff <= ST_REPLY;
               end else if (free_found) begin
                  used_ff[rd_slot]   <= 1'b1;
                  ident_ff[rd_slot]  <= next_ident_ff;
                  sowner_ff[rd_slot] <= owner_ff;
                  next_ident_ff      <= (next_ident_ff == '1) ? IdentW'(1)
                                                              : next_ident_ff + 1'b1;
                  rep_st_ff          <= 1'b0;
                  rep_ident_ff       <= next_ident_ff;
                  rep_pid_ff         <= owner_ff;
                  state_ff           <= ST_UPD;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FIND: begin
               if (find_end) begin
                  state_ff <= ST_REPLY;
               end else if (id_match) begin
                  rep_st_ff  <= 1'b0;
                  rep_pid_ff <= sowner_ff[rd_slot];
                  if (kind_ff == KIND_RELEASE) begin
                     used_ff[rd_slot]  <= 1'b0;
                     ident_ff[rd_slot] <= '0;
                     idx_ff            <= '0;
                     state_ff          <= ST_PAINT;
                  end else begin
                     state_ff <= ST_UPD;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_PAINT: begin
               // one update per remaining window, at most MaxUpdates, bottom to top
               if (!paint_more) begin
                  state_ff <= ST_REPLY;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b0;
                  rsp_st_ff    <= 1'b0;
                  rsp_ident_ff <= '0;
                  rsp_pid_ff   <= sowner_ff[rd_slot];
                  rsp_last_ff  <= 1'b0;
                  idx_ff       <= idx_ff + 1'b1;
               end
            end
            ST_HIT: begin
               // top down, first window holding the point wins
               if (idx_ff == '0) begin
                  state_ff <= ST_REPLY;
               end else if (pt_hit) begin
                  rep_st_ff  <= 1'b0;
                  rep_pid_ff <= sowner_ff[rd_slot];
                  state_ff   <= ST_REPLY;
               end else begin
                  idx_ff <= idx_m1;
               end
            end
            ST_UPD: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b0;
                  rsp_st_ff    <= 1'b0;
                  rsp_ident_ff <= '0;
                  rsp_pid_ff   <= rep_pid_ff;
                  rsp_last_ff  <= 1'b0;
                  state_ff     <= ST_REPLY;
               end
            end
            ST_REPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= 1'b1;
                  rsp_st_ff    <= rep_st_ff;
                  rsp_ident_ff <= rep_ident_ff;
                  rsp_pid_ff   <= rep_pid_ff;
                  rsp_last_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // stack never holds more windows than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count <= MaxCount)
      else $error("stack count above table size");

   // a failed reply carries no owner and no id
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_owner_pid == '0 && rsp_window_ident == '0)
      else $error("failed reply carries data");

   // the final flag marks exactly the reply item
   a_last_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_result_kind)
      else $error("last flag does not match result kind");

   // next id is never zero
   a_ident_nonzero: assert property (@(posedge clock) disable iff (reset)
      next_ident_ff != '0)
      else $error("next id became zero");

   // a reply leaves the block idle on the next edge
   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REPLY && out_free |=> state_ff == ST_IDLE && !req_stall)
      else $error("not idle after reply");
endmodule
`default_nettype wire

// ----- verif/window_zorder_hit_test_tb.sv -----
// ----------------------------------------------------------------------------
// window_zorder_hit_test_tb
// drives allocate, release, activate and hit test requests with random gaps
// and stalls, predicts every update and reply from a model of the window
// table and stacking order, and checks each result in arrival order
// ----------------------------------------------------------------------------
module window_zorder_hit_test_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wzh_pkg::*;

   localparam int NumSlots = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = KIND_HIT;
   logic [15:0] req_window_id = '0;
   logic [11:0] req_left_x = '0;
   logic [11:0] req_top_y = '0;
   logic [11:0] req_right_x = '0;
   logic [11:0] req_bottom_y = '0;
   logic [15:0] req_owner = '0;
   logic [11:0] req_point_x = '0;
   logic [11:0] req_point_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic        rsp_status;
   logic [15:0] rsp_window_ident;
   logic [15:0] rsp_owner_pid;
   logic        rsp_last;

   typedef struct packed {
      logic        result_kind;
      logic        status;
      logic [15:0] ident;
      logic [15:0] pid;
      logic        last;
   } window_result_type;

   window_result_type pending_results[$];
   int mismatch_count = 0;
   int unexpected_count = 0;
   bit stall_enable = 1'b1;

   // model of the window table
   bit          win_used[NumSlots];
   logic [15:0] win_ident[NumSlots];
   logic [15:0] win_owner[NumSlots];
   rect_type    win_rect[NumSlots];
   int          z_stack[$];
   logic [15:0] ident_next;

   window_zorder_hit_test uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("window_zorder_hit_test_tb NOT OK");
      $finish;
   end

   function automatic window_result_type make_result(bit rk, bit st, logic [15:0] id,
                                                    logic [15:0] pid, bit lst);
      window_result_type r;
      r.result_kind = rk;
      r.status = st;
      r.ident = id;
      r.pid = pid;
      r.last = lst;
      return r;
   endfunction

   // lowest live entry in the stack holding this id
   function automatic int find_stack_pos(logic [15:0] id);
      foreach (z_stack[i])
         if (win_used[z_stack[i]] && win_ident[z_stack[i]] == id)
            return i;
      return -1;
   endfunction

   task automatic predict_window_op(logic [1:0] kind, logic [15:0] id, rect_type rc,
                                    logic [15:0] own, point_type pt);
      int s;
      int pos;
      s = -1;
      case (kind)
         KIND_ALLOC: begin
            for (int i = NumSlots - 1; i >= 0; i--)
               if (!win_used[i]) s = i;
            if (s < 0) begin
               pending_results.push_back(make_result(1, 1, 0, 0, 1));
            end else begin
               win_used[s] = 1;
               win_ident[s] = ident_next;
               win_owner[s] = own;
               win_rect[s] = rc;
               z_stack.push_back(s);
               pending_results.push_back(make_result(0, 0, 0, own, 0));
               pending_results.push_back(make_result(1, 0, ident_next, own, 1));
               ident_next = (ident_next == 16'hFFFF) ? 16'd1 : ident_next + 16'd1;
            end
         end
         KIND_RELEASE, KIND_ACTIVATE: begin
            pos = find_stack_pos(id);
            if (pos < 0) begin
               pending_results.push_back(make_result(1, 1, 0, 0, 1));
            end else begin
               s = z_stack[pos];
               z_stack.delete(pos);
               if (kind == KIND_RELEASE) begin
                  win_used[s] = 0;
                  win_ident[s] = 0;
                  foreach (z_stack[i])
                     if (i < MaxUpdates)
                        pending_results.push_back(make_result(0, 0, 0,
                                                              win_owner[z_stack[i]], 0));
               end else begin
                  z_stack.push_back(s);
                  pending_results.push_back(make_result(0, 0, 0, win_owner[s], 0));
               end
               pending_results.push_back(make_result(1, 0, 0, win_owner[s], 1));
            end
         end
         default: begin
            // topmost window whose half-open rectangle holds the point
            for (int i = z_stack.size() - 1; i >= 0 && s < 0; i--) begin
               rect_type r;
               r = win_rect[z_stack[i]];
               if (r.left <= pt.x && r.right > pt.x && r.top <= pt.y && r.bottom > pt.y)
                  s = z_stack[i];
            end
            if (s < 0) pending_results.push_back(make_result(1, 1, 0, 0, 1));
            else pending_results.push_back(make_result(1, 0, 0, win_owner[s], 1));
         end
      endcase
   endtask

   function automatic int random_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(5, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // send one request and predict its results when it is accepted
   task automatic send_request(logic [1:0] kind, logic [15:0] id, rect_type rc,
                               logic [15:0] own, point_type pt);
      int gap;
      gap = random_gap();
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_window_id <= id;
      req_left_x <= rc.left;
      req_top_y <= rc.top;
      req_right_x <= rc.right;
      req_bottom_y <= rc.bottom;
      req_owner <= own;
      req_point_x <= pt.x;
      req_point_y <= pt.y;
      do @(posedge clock); while (req_stall);
      predict_window_op(kind, id, rc, own, pt);
      @(negedge clock);
   endtask

   function automatic rect_type random_rect();
      rect_type r;
      r.left = 12'($urandom_range(0, 3000));
      r.top = 12'($urandom_range(0, 3000));
      r.right = 12'(r.left + $urandom_range(1, 1095));
      r.bottom = 12'(r.top + $urandom_range(1, 1095));
      if ($urandom_range(0, 15) == 0) r = rect_type'($urandom());
      if ($urandom_range(0, 31) == 0) r = rect_type'({$urandom(), $urandom()});
      return r;
   endfunction

   function automatic point_type random_point();
      point_type p;
      p.x = 12'($urandom_range(0, 4095));
      p.y = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0 && z_stack.size() > 0) begin
         rect_type r;
         r = win_rect[z_stack[$urandom_range(0, z_stack.size() - 1)]];
         p.x = 12'(r.left + $urandom_range(0, 1));
         p.y = 12'(r.bottom - $urandom_range(0, 1));
      end
      return p;
   endfunction

   // id of a random live window, sometimes a dead or bogus one
   function automatic logic [15:0] pick_ident();
      if (z_stack.size() > 0 && $urandom_range(0, 7) != 0)
         return win_ident[z_stack[$urandom_range(0, z_stack.size() - 1)]];
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic random_request();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30)
         send_request(KIND_ALLOC, 16'($urandom()), random_rect(), 16'($urandom()),
                      random_point());
      else if (sel < 50)
         send_request(KIND_RELEASE, pick_ident(), random_rect(), 16'($urandom()),
                      random_point());
      else if (sel < 70)
         send_request(KIND_ACTIVATE, pick_ident(), random_rect(), 16'($urandom()),
                      random_point());
      else
         send_request(KIND_HIT, pick_ident(), random_rect(), 16'($urandom()),
                      random_point());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() > 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // edges of the fields, full table, unknown ids, empty rectangles, misses
   task automatic test_directed();
      rect_type full_rect;
      rect_type empty_rect;
      point_type pt;
      full_rect = '{left: 0, top: 0, right: 12'hFFF, bottom: 12'hFFF};
      empty_rect = '{left: 12'h100, top: 12'h100, right: 12'h100, bottom: 12'h200};
      pt = '{x: 0, y: 0};
      send_request(KIND_HIT, 0, full_rect, 0, pt);
      send_request(KIND_RELEASE, 0, full_rect, 0, pt);
      send_request(KIND_ACTIVATE, 16'hFFFF, full_rect, 0, pt);
      send_request(KIND_ALLOC, 16'hFFFF, full_rect, 16'hFFFF, pt);
      send_request(KIND_ALLOC, 0, empty_rect, 16'h0001, pt);
      send_request(KIND_HIT, 0, full_rect, 0, '{x: 12'hFFE, y: 12'hFFE});
      send_request(KIND_HIT, 0, full_rect, 0, '{x: 12'hFFF, y: 0});
      send_request(KIND_HIT, 0, full_rect, 0, '{x: 12'h100, y: 12'h100});
      send_request(KIND_ACTIVATE, 1, full_rect, 0, pt);
      send_request(KIND_HIT, 0, full_rect, 0, '{x: 12'h5A5, y: 12'hA5A});
      // fill the table, then overflow it
      for (int i = 0; i < 15; i++)
         send_request(KIND_ALLOC, 0, random_rect(), 16'(16'h1000 + i), pt);
      send_request(KIND_ALLOC, 0, full_rect, 16'h7777, pt);
      send_request(KIND_RELEASE, 2, full_rect, 0, pt);
      send_request(KIND_RELEASE, 2, full_rect, 0, pt);
      wait_drained();
   endtask

   task automatic test_random_mix();
      for (int i = 0; i < 380; i++) random_request();
      wait_drained();
   endtask

   // churn one window: allocate it, then release it by its fresh id
   task automatic test_ident_wrap();
      stall_enable = 1'b0;
      for (int i = 0; i < 20; i++) begin
         logic [15:0] id;
         id = ident_next;
         send_request(KIND_ALLOC, 0, random_rect(), id, random_point());
         send_request(KIND_RELEASE, id, random_rect(), 0, random_point());
      end
      stall_enable = 1'b1;
      for (int i = 0; i < 60; i++) random_request();
      wait_drained();
   endtask

   initial begin
      foreach (win_used[i]) begin
         win_used[i] = 0;
         win_ident[i] = 0;
         win_owner[i] = 0;
         win_rect[i] = '0;
      end
      ident_next = 16'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix();
      test_ident_wrap();
      if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0)
         $display("window_zorder_hit_test_tb OK");
      else
         $display("window_zorder_hit_test_tb NOT OK");
      $finish;
   end

   // random stall on the result side
   initial begin
      forever begin
         @(negedge clock);
         if (stall_enable && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (random_gap() + 1) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         window_result_type got;
         window_result_type want;
         got = make_result(rsp_result_kind, rsp_status, rsp_window_ident,
                           rsp_owner_pid, rsp_last);
         if (pending_results.size() == 0) begin
            unexpected_count++;
            if (unexpected_count <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

endmodule

// ----- sim.f -----
sv/wzh_pkg.sv
sv/wzh_rect_cmp.sv
sv/wzh_stack.sv
sv/window_zorder_hit_test.sv
verif/window_zorder_hit_test_tb.sv
